/* src/msa_pkg.sv */
`timescale 1ns / 1ps
package msa_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef struct packed {
        logic        op;
        logic [63:0] leaf_w0;
        logic [63:0] leaf_w1;
        logic [63:0] leaf_w2;
        logic [63:0] leaf_w3;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic        root_valid;
        logic [63:0] root_w0;
        logic [63:0] root_w1;
        logic [63:0] root_w2;
        logic [63:0] root_w3;
        logic [31:0] leaves_added;
    } result_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_ROOT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CHK,
        ST_ADD_HASH,
        ST_ADD_WAIT,
        ST_ROOT_RD,
        ST_ROOT_CHK,
        ST_ROOT_HASH,
        ST_ROOT_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_ROUND,
        HS_ADD
    } hstate_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // padding block for a 64-byte message
    localparam logic [511:0] PAD_BLOCK = {32'h80000000, 448'h0, 32'd512};

endpackage

/* src/msa_hash.sv */
`timescale 1ns / 1ps
// SHA-256 of a 64-byte message: two compressions on one round unit.
module msa_hash (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [511:0] msg,
    output logic         done,
    output logic [255:0] digest
);

    msa_pkg::hstate_t state_reg, state_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         blk_reg, blk_next;
    logic [511:0] w_reg, w_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;

    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;
    logic [31:0] w1, w9, w14;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = v_reg;
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + msa_pkg::round_k(rnd_reg) + w_reg[511:480];
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));
        w1  = w_reg[479:448];
        w9  = w_reg[223:192];
        w14 = w_reg[63:32];
        s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
        s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
        wn = w_reg[511:480] + s0 + w9 + s1;
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next = rnd_reg;
        blk_next = blk_reg;
        w_next = w_reg;
        h_next = h_reg;
        v_next = v_reg;
        case (state_reg)
            msa_pkg::HS_IDLE:
            begin
                if (go)
                begin
                    w_next = msg;
                    h_next = msa_pkg::INIT_H;
                    v_next = msa_pkg::INIT_H;
                    rnd_next = '0;
                    blk_next = 1'b0;
                    state_next = msa_pkg::HS_ROUND;
                end
            end
            msa_pkg::HS_ROUND:
            begin
                v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next = {w_reg[479:0], wn};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = msa_pkg::HS_ADD;
            end
            msa_pkg::HS_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
                if (!blk_reg)
                begin
                    v_next = h_next;
                    w_next = msa_pkg::PAD_BLOCK;
                    blk_next = 1'b1;
                    state_next = msa_pkg::HS_ROUND;
                end
                else
                    state_next = msa_pkg::HS_IDLE;
            end
            default: state_next = msa_pkg::HS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msa_pkg::HS_IDLE;
            rnd_reg <= '0;
            blk_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
            blk_reg <= blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        h_reg <= h_next;
        v_reg <= v_next;
    end

    always_comb
    begin
        done = (state_reg == msa_pkg::HS_ADD) && blk_reg;
        digest = h_next;
    end

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msa_pkg::HS_ADD) |-> ($past(rnd_reg) == 6'd63))
        else $error("final add without 64 rounds");
    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == msa_pkg::HS_IDLE))
        else $error("hash did not return idle");
    a_pad_second: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blk_reg) |-> (state_reg == msa_pkg::HS_ROUND))
        else $error("second block not started");

endmodule

/* src/merkle_state_accumulator.sv */
`timescale 1ns / 1ps
// Channel   Ports                       Handshake
// command   start, busy, cmd            beat taken when start && !busy
// result    res_valid, res              one-cycle strobe, no back-pressure
//
// One command is in flight at a time; busy stays high until its result strobes.
// Each SHA-256 pair hash runs on one round unit; a hashed slot also costs the slot read,
// check and go states. An add chains at most SLOTS-1 hashes before its result strobes.
// Slot words sit in a RAM read one slot a cycle, so each slot visit costs a read.
// Reset clears slot flags, counts and the sequencer; slot data needs no clear.
module merkle_state_accumulator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  msa_pkg::cmd_t     cmd,
    output logic              res_valid,
    output msa_pkg::result_t  res
);

    msa_pkg::state_t state_reg, state_next;
    logic [255:0] mem [msa_pkg::SLOTS];
    logic [255:0] rd_reg;
    logic [255:0] acc_reg, acc_next;
    logic         have_reg, have_next;
    logic [msa_pkg::SLOTS-1:0] full_reg, full_next;
    logic [msa_pkg::CNT_W-1:0] used_reg, used_next;
    logic [msa_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [31:0]  total_reg, total_next;
    logic         rej_reg, rej_next;
    logic         we;
    logic [255:0] wdata;
    logic         hgo, hdone;
    logic [255:0] hdig;
    logic [msa_pkg::SLOT_W-1:0] idx_a;
    logic         last_full;

    assign idx_a = idx_reg[msa_pkg::SLOT_W-1:0];

    msa_hash u_hash (
        .clk(clk), .rst_n(rst_n), .go(hgo),
        .msg({rd_reg, acc_reg}), .done(hdone), .digest(hdig)
    );

    always_ff @(posedge clk)
    begin
        if (we)
            mem[idx_a] <= wdata;
        rd_reg <= mem[idx_a];
    end

    always_comb
    begin
        last_full = 1'b1;
        if (used_reg != '0)
            last_full = full_reg[msa_pkg::SLOT_W'(used_reg - 1'b1)];
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next = acc_reg;
        have_next = have_reg;
        full_next = full_reg;
        used_next = used_reg;
        idx_next = idx_reg;
        total_next = total_reg;
        rej_next = rej_reg;
        case (state_reg)
            msa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    have_next = 1'b0;
                    rej_next = 1'b0;
                    acc_next = {cmd.leaf_w0, cmd.leaf_w1, cmd.leaf_w2, cmd.leaf_w3};
                    if (cmd.op == msa_pkg::OP_ROOT)
                        state_next = msa_pkg::ST_ROOT_RD;
                    else if (last_full && used_reg == msa_pkg::CNT_W'(msa_pkg::SLOTS))
                    begin
                        rej_next = 1'b1;
                        state_next = msa_pkg::ST_DONE;
                    end
                    else
                    begin
                        if (last_full)
                        begin
                            full_next[msa_pkg::SLOT_W'(used_reg)] = 1'b0;
                            used_next = used_reg + 1'b1;
                        end
                        total_next = total_reg + 32'd1;
                        state_next = msa_pkg::ST_ADD_RD;
                    end
                end
            end
            msa_pkg::ST_ADD_RD: state_next = msa_pkg::ST_ADD_CHK;
            msa_pkg::ST_ADD_CHK:
            begin
                if (!full_reg[idx_a])
                begin
                    full_next[idx_a] = 1'b1;
                    state_next = msa_pkg::ST_DONE;
                end
                else
                    state_next = msa_pkg::ST_ADD_HASH;
            end
            msa_pkg::ST_ADD_HASH: state_next = msa_pkg::ST_ADD_WAIT;
            msa_pkg::ST_ADD_WAIT:
            begin
                if (hdone)
                begin
                    acc_next = hdig;
                    full_next[idx_a] = 1'b0;
                    idx_next = idx_reg + 1'b1;
                    // the last slot in use is empty, so the walk ends in range
                    state_next = msa_pkg::ST_ADD_RD;
                end
            end
            msa_pkg::ST_ROOT_RD:
            begin
                if (idx_reg == used_reg)
                    state_next = msa_pkg::ST_DONE;
                else
                    state_next = msa_pkg::ST_ROOT_CHK;
            end
            msa_pkg::ST_ROOT_CHK:
            begin
                if (!full_reg[idx_a])
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = msa_pkg::ST_ROOT_RD;
                end
                else if (!have_reg)
                begin
                    acc_next = rd_reg;
                    have_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = msa_pkg::ST_ROOT_RD;
                end
                else
                    state_next = msa_pkg::ST_ROOT_HASH;
            end
            msa_pkg::ST_ROOT_HASH: state_next = msa_pkg::ST_ROOT_WAIT;
            msa_pkg::ST_ROOT_WAIT:
            begin
                if (hdone)
                begin
                    acc_next = hdig;
                    idx_next = idx_reg + 1'b1;
                    state_next = msa_pkg::ST_ROOT_RD;
                end
            end
            msa_pkg::ST_DONE: state_next = msa_pkg::ST_IDLE;
            default: state_next = msa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != msa_pkg::ST_IDLE);
        hgo = (state_reg == msa_pkg::ST_ADD_HASH) || (state_reg == msa_pkg::ST_ROOT_HASH);
        we = (state_reg == msa_pkg::ST_ADD_CHK) && !full_reg[idx_a];
        wdata = acc_reg;
        res_valid = (state_reg == msa_pkg::ST_DONE);
        res.status = rej_reg;
        res.root_valid = have_reg;
        res.root_w0 = have_reg ? acc_reg[255:192] : 64'd0;
        res.root_w1 = have_reg ? acc_reg[191:128] : 64'd0;
        res.root_w2 = have_reg ? acc_reg[127:64] : 64'd0;
        res.root_w3 = have_reg ? acc_reg[63:0] : 64'd0;
        res.leaves_added = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msa_pkg::ST_IDLE;
            full_reg <= '0;
            used_reg <= '0;
            idx_reg <= '0;
            total_reg <= '0;
            rej_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg <= full_next;
            used_reg <= used_next;
            idx_reg <= idx_next;
            total_reg <= total_next;
            rej_reg <= rej_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= msa_pkg::CNT_W'(msa_pkg::SLOTS))
        else $error("slot count overflow");
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status) |-> $stable(total_reg) && $stable(used_reg))
        else $error("rejected add changed state");
    a_full_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg >> used_reg) == '0)
        else $error("full slot beyond slots in use");
    a_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
        hdone |-> (state_reg == msa_pkg::ST_ADD_WAIT || state_reg == msa_pkg::ST_ROOT_WAIT))
        else $error("hash done out of place");

endmodule

/* tb/merkle_state_accumulator_tb.sv */
`timescale 1ns / 1ps
module merkle_state_accumulator_tb;

    import msa_pkg::*;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        cmd_t        c;
        int unsigned pause;
    } beat_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    res_valid;
    result_t res;

    beat_t   pending[$];
    result_t expected_results[$];
    int      errors;
    logic    taken;
    int unsigned hold_cnt;

    // mirror of the slot row
    logic [255:0] slot_val [SLOTS];
    bit           slot_on [SLOTS];
    int           in_use;
    logic [31:0]  leaf_count;

    merkle_state_accumulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_compress(input logic [255:0] hin,
                                                  input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        a = hin[255:224]; b = hin[223:192]; c = hin[191:160]; d = hin[159:128];
        e = hin[127:96];  f = hin[95:64];   g = hin[63:32];   h = hin[31:0];
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        return {hin[255:224] + a, hin[223:192] + b, hin[191:160] + c, hin[159:128] + d,
                hin[127:96] + e, hin[95:64] + f, hin[63:32] + g, hin[31:0] + h};
    endfunction

    function automatic logic [255:0] pair_digest(input logic [255:0] left,
                                                 input logic [255:0] right);
        logic [255:0] st;
        st = sha_compress(SHA_IV, {left, right});
        return sha_compress(st, {32'h80000000, 448'h0, 32'd512});
    endfunction

    // advance the mirror by one command and queue the result it must produce
    task automatic predict_merkle(input cmd_t c);
        result_t      r;
        logic [255:0] acc;
        bit           have;
        r = '0;
        if (c.op == OP_ADD)
        begin
            if (in_use == 0 || slot_on[in_use - 1])
            begin
                if (in_use >= SLOTS)
                begin
                    r.status = 1'b1;
                    r.leaves_added = leaf_count;
                    expected_results.push_back(r);
                    return;
                end
                slot_on[in_use] = 1'b0;
                in_use++;
            end
            leaf_count++;
            acc = {c.leaf_w0, c.leaf_w1, c.leaf_w2, c.leaf_w3};
            for (int i = 0; i < in_use; i++)
            begin
                if (!slot_on[i])
                begin
                    slot_val[i] = acc;
                    slot_on[i] = 1'b1;
                    break;
                end
                acc = pair_digest(slot_val[i], acc);
                slot_on[i] = 1'b0;
            end
        end
        else
        begin
            have = 1'b0;
            acc = '0;
            for (int i = 0; i < in_use; i++)
            begin
                if (slot_on[i])
                begin
                    acc = have ? pair_digest(slot_val[i], acc) : slot_val[i];
                    have = 1'b1;
                end
            end
            r.root_valid = have;
            {r.root_w0, r.root_w1, r.root_w2, r.root_w3} = acc;
        end
        r.leaves_added = leaf_count;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got %h, want %h", $time, what, got, want);
        errors++;
    endtask

    // accept commands and check results
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                predict_merkle(cmd);
            if (res_valid)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", res.leaves_added, 64'h0);
                else
                begin
                    want = expected_results.pop_front();
                    if (res.status !== want.status)
                        report_mismatch("status", res.status, want.status);
                    if (res.root_valid !== want.root_valid)
                        report_mismatch("root_valid", res.root_valid, want.root_valid);
                    if (res.root_w0 !== want.root_w0)
                        report_mismatch("root_w0", res.root_w0, want.root_w0);
                    if (res.root_w1 !== want.root_w1)
                        report_mismatch("root_w1", res.root_w1, want.root_w1);
                    if (res.root_w2 !== want.root_w2)
                        report_mismatch("root_w2", res.root_w2, want.root_w2);
                    if (res.root_w3 !== want.root_w3)
                        report_mismatch("root_w3", res.root_w3, want.root_w3);
                    if (res.leaves_added !== want.leaves_added)
                        report_mismatch("leaves_added", res.leaves_added,
                                        want.leaves_added);
                end
            end
        end
        taken <= rst_n && start && !busy;
    end

    // drive the next beat after its pause, hold start until taken
    always @(negedge clk)
    begin
        logic nx_start;
        beat_t b;
        nx_start = start;
        if (!rst_n)
            nx_start = 1'b0;
        else
        begin
            if (start && taken)
                nx_start = 1'b0;
            if (!nx_start && pending.size() > 0)
            begin
                if (hold_cnt < pending[0].pause)
                    hold_cnt++;
                else
                begin
                    b = pending.pop_front();
                    cmd <= b.c;
                    nx_start = 1'b1;
                    hold_cnt = 0;
                end
            end
        end
        start <= nx_start;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_cmd(input logic op, input logic [255:0] leaf,
                            input int unsigned pause);
        beat_t b;
        b.c.op = op;
        {b.c.leaf_w0, b.c.leaf_w1, b.c.leaf_w2, b.c.leaf_w3} = leaf;
        b.pause = pause;
        pending.push_back(b);
    endtask

    // wait until every beat is taken and its result checked
    task automatic drain();
        while (pending.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        int unsigned pause;
        bit burst;
        errors = 0;
        in_use = 0;
        leaf_count = '0;
        hold_cnt = 0;
        taken = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_on[i] = 1'b0;
            slot_val[i] = '0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty root, extreme leaves, roots between carries
        push_cmd(OP_ROOT, '1, 0);
        push_cmd(OP_ADD, '0, 0);
        push_cmd(OP_ROOT, '0, 3);
        push_cmd(OP_ADD, '1, 0);
        push_cmd(OP_ROOT, '0, 0);
        push_cmd(OP_ADD, {64'h0123456789abcdef, 64'hfedcba9876543210,
                          64'h8000000000000001, 64'h7ffffffffffffffe}, 1);
        push_cmd(OP_ROOT, '0, 0);
        push_cmd(OP_ADD, {4{64'haaaaaaaaaaaaaaaa}}, 8);
        push_cmd(OP_ROOT, '0, 2);
        push_cmd(OP_ADD, {4{64'h5555555555555555}}, 0);
        push_cmd(OP_ROOT, '1, 0);

        for (int i = 0; i < 270; i++)
        begin
            if (i % 40 == 0)
                burst = $urandom_range(0, 2) == 0;
            pause = burst ? 0 : $urandom_range(0, 8);
            push_cmd($urandom_range(0, 4) == 0 ? OP_ROOT : OP_ADD,
                     {rand_word(), rand_word(), rand_word(), rand_word()}, pause);
        end
        drain();

        // restart from an idle block
        push_cmd(OP_ROOT, '0, 1);
        push_cmd(OP_ADD, '1, 0);
        push_cmd(OP_ADD, '0, 4);
        push_cmd(OP_ROOT, '0, 0);
        push_cmd(OP_ADD, {rand_word(), rand_word(), rand_word(), rand_word()}, 2);
        push_cmd(OP_ROOT, '0, 7);
        drain();

        if (errors == 0)
            $display("merkle_state_accumulator: match");
        else
            $display("merkle_state_accumulator: mismatch");
        $finish;
    end

    initial
    begin
        #(64'd40_000_000 * 12);
        $display("merkle_state_accumulator: mismatch");
        $finish;
    end

endmodule
